// ----- hdl/ps2mt_pkg.sv -----
// Shared types and constants for the PS/2 mouse packet tracker.
package ps2mt_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int LIMIT_BITS         = 12;
   localparam int CSR_DATA_BITS      = 32;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int REQ_DATA_BITS      = 8;
   localparam int RSP_DATA_BITS      = 56;

   localparam int POS_X_RESET = 400;
   localparam int POS_Y_RESET = 300;
   localparam logic [LIMIT_BITS-1:0] MAX_X_RESET = 12'd1023;
   localparam logic [LIMIT_BITS-1:0] MAX_Y_RESET = 12'd767;

   // Header byte bit positions.
   localparam int HDR_SYNC_BIT   = 3;
   localparam int HDR_X_SIGN_BIT = 4;
   localparam int HDR_Y_SIGN_BIT = 5;

   // Register select, taken from address bit 2.
   localparam logic REG_MAX_X = 1'b0;
   localparam logic REG_MAX_Y = 1'b1;

   typedef struct packed {
      logic       fire;
      logic       aux;
      logic [7:0] data;
   } step_type;

   typedef struct packed {
      logic              valid;
      logic signed [8:0] delta_x;
      logic signed [9:0] delta_y;
      logic [2:0]        buttons;
   } packet_type;

   typedef struct packed {
      logic signed [8:0] delta_x;
      logic signed [9:0] delta_y;
      logic [11:0]       abs_x;
      logic [11:0]       abs_y;
      logic [2:0]        buttons;
      logic [2:0]        prior_buttons;
   } report_type;

endpackage

// ----- hdl/ps2_mouse_packet_tracker.sv -----
// Top level of the PS/2 mouse packet tracker: input stage, result register, submodules.
//
//   Port group  Direction  Carries
//   req_*       in         one byte from the controller with its aux flag
//   rsp_*       out        one movement report per completed packet
//   csr_*       in/out     position limits max_x (0x0) and max_y (0x4)
//
// A byte is taken into an input register and moves on once the result register is free or
// being drained; the report of a completing byte is registered in the result register, which drives rsp_tvalid.
// One byte per cycle is sustained while rsp_tready stays high. While a report waits, one
// more byte is taken into the input register and req_tready then stays low until it leaves.
// Reset clears the packet phase, sets the position to 400,300 and the limits to
// 1023,767; no clearing pass is needed.
module ps2_mouse_packet_tracker
   import ps2mt_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [7:0] packet_byte
   input  logic [0:0]               req_tuser,   // [0] from_aux
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [8:0] delta_x, [18:9] delta_y, [30:19] abs_x, [42:31] abs_y,
   // [45:43] button_bits, [48:46] previous_button_bits, [55:49] zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_aux_ff;
   logic                  out_valid_ff, out_valid_in;
   report_type            out_report_ff;
   logic                  advance;
   logic                  req_take;
   step_type              step;
   packet_type            packet;
   report_type            report;
   logic [LIMIT_BITS-1:0] max_x;
   logic [LIMIT_BITS-1:0] max_y;

   ps2mt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_x       (max_x),
      .max_y       (max_y)
   );

   // The held byte moves on whenever the result register is free or being drained.
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   assign step.fire = advance;
   assign step.aux  = in_aux_ff;
   assign step.data = in_byte_ff;

   ps2mt_assembler u_assembler (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .packet (packet)
   );

   ps2mt_tracker #(
      .COORD_BITS (COORD_BITS)
   ) u_tracker (
      .clock  (clock),
      .reset  (reset),
      .packet (packet),
      .max_x  (max_x),
      .max_y  (max_y),
      .report (report)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (packet.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata[7:0];
         in_aux_ff  <= req_tuser[0];
      end
      if (packet.valid) begin
         out_report_ff <= report;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        out_report_ff.prior_buttons,
                        out_report_ff.buttons,
                        out_report_ff.abs_y,
                        out_report_ff.abs_x,
                        out_report_ff.delta_y,
                        out_report_ff.delta_x};

endmodule

// ----- hdl/ps2mt_csr.sv -----
// Configuration registers holding the horizontal and vertical position limits.
module ps2mt_csr
   import ps2mt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [LIMIT_BITS-1:0]    max_x,
   output logic [LIMIT_BITS-1:0]    max_y
);

   logic [LIMIT_BITS-1:0] max_x_ff, max_x_in;
   logic [LIMIT_BITS-1:0] max_y_ff, max_y_in;
   logic                  wr_en;
   logic                  reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MAX_X: max_x_in = csr_pwdata[LIMIT_BITS-1:0];
            REG_MAX_Y: max_y_in = csr_pwdata[LIMIT_BITS-1:0];
            default:   max_x_in = max_x_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_X: csr_prdata = CSR_DATA_BITS'(max_x_ff);
         REG_MAX_Y: csr_prdata = CSR_DATA_BITS'(max_y_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= MAX_X_RESET;
         max_y_ff <= MAX_Y_RESET;
      end else begin
         max_x_ff <= max_x_in;
         max_y_ff <= max_y_in;
      end
   end

   assign max_x = max_x_ff;
   assign max_y = max_y_ff;

endmodule

// ----- hdl/ps2mt_assembler.sv -----
// Collects header, X and Y bytes into a packet and forms the signed deltas.
module ps2mt_assembler
   import ps2mt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  step_type   step,
   output packet_type packet
);

   typedef enum logic [2:0] {
      WAIT_HDR = 3'b001,
      WAIT_X   = 3'b010,
      WAIT_Y   = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] x_byte_ff, x_byte_in;
   logic       take;

   assign take = step.fire & step.aux;

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      x_byte_in = x_byte_ff;
      if (take) begin
         case (phase_ff)
            WAIT_X: begin
               x_byte_in = step.data;
               phase_in  = WAIT_Y;
            end
            WAIT_Y: begin
               phase_in = WAIT_HDR;
            end
            default: begin
               // A header without the sync bit is dropped to regain alignment.
               if (step.data[HDR_SYNC_BIT]) begin
                  header_in = step.data;
                  phase_in  = WAIT_X;
               end else begin
                  phase_in = WAIT_HDR;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= WAIT_HDR;
         header_ff <= '0;
         x_byte_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         x_byte_ff <= x_byte_in;
      end
   end

   always_comb begin
      packet.valid   = take & (phase_ff == WAIT_Y);
      packet.delta_x = $signed({header_ff[HDR_X_SIGN_BIT], x_byte_ff});
      // Vertical movement is negated so that screen-down is positive.
      packet.delta_y = 10'sd0 - $signed({header_ff[HDR_Y_SIGN_BIT],
                                         header_ff[HDR_Y_SIGN_BIT], step.data});
      packet.buttons = header_ff[2:0];
   end

endmodule

// ----- hdl/ps2mt_tracker.sv -----
// Holds the pointer position and button state and applies each packet.
module ps2mt_tracker
   import ps2mt_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  packet_type            packet,
   input  logic [LIMIT_BITS-1:0] max_x,
   input  logic [LIMIT_BITS-1:0] max_y,
   output report_type            report
);

   localparam int LW = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;
   localparam int SW = LW + 2;
   localparam logic [LW-1:0] COORD_MAX = LW'((33'd1 << COORD_BITS) - 33'd1);

   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [2:0]            buttons_ff, buttons_in;
   logic [COORD_BITS-1:0] new_x, new_y;
   logic [31:0]           wide_x, wide_y;

   function automatic logic [COORD_BITS-1:0] move_clamp(
      input logic [COORD_BITS-1:0] pos,
      input logic signed [SW-1:0]  delta,
      input logic [LIMIT_BITS-1:0] reg_max
   );
      logic [LW-1:0]        reg_ext;
      logic [LW-1:0]        lim;
      logic signed [SW-1:0] sum;
      logic signed [SW-1:0] lim_s;
      logic [LW-1:0]        res;
      reg_ext = LW'(reg_max);
      lim     = (reg_ext < COORD_MAX) ? reg_ext : COORD_MAX;
      sum     = $signed({2'b00, LW'(pos)}) + delta;
      lim_s   = $signed({2'b00, lim});
      if (sum[SW-1]) begin
         res = '0;
      end else if (sum > lim_s) begin
         res = lim;
      end else begin
         res = sum[LW-1:0];
      end
      return COORD_BITS'(res);
   endfunction

   assign new_x = move_clamp(pos_x_ff, SW'(packet.delta_x), max_x);
   assign new_y = move_clamp(pos_y_ff, SW'(packet.delta_y), max_y);

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      buttons_in = buttons_ff;
      if (packet.valid) begin
         pos_x_in   = new_x;
         pos_y_in   = new_y;
         buttons_in = packet.buttons;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= COORD_BITS'(POS_X_RESET);
         pos_y_ff   <= COORD_BITS'(POS_Y_RESET);
         buttons_ff <= '0;
      end else begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         buttons_ff <= buttons_in;
      end
   end

   assign wide_x = 32'(new_x);
   assign wide_y = 32'(new_y);

   always_comb begin
      report.delta_x       = packet.delta_x;
      report.delta_y       = packet.delta_y;
      report.abs_x         = wide_x[11:0];
      report.abs_y         = wide_y[11:0];
      report.buttons       = packet.buttons;
      report.prior_buttons = buttons_ff;
   end

endmodule

// ----- hdl/ps2mt_checker.sv -----
// Port-level checks for the PS/2 mouse packet tracker and their binding.
module ps2mt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // The input side only stalls while a report is blocked at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a blocked report");

   // A report out of an empty output comes from an aux byte taken through the input register.
   a_report_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tuser[0], 2))
      else $error("report appeared without a matching aux byte");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("report valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled report changed or dropped");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_checker (.*);
